// ----- hw/rtl/gkq_pkg.sv -----
// ----------------------------------------------------------------------------
// gkq_pkg
// Shared types and constants of the Gaussian kernel density unit: word
// layouts of both channels, operation and status codes, fixed-point constants.
// ----------------------------------------------------------------------------
package gkq_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_DENSITY  = 2'd2,
    OP_QUANTILE = 2'd3
  } op_e;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] value;
    logic [15:0]        ratio;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        density;
    logic signed [31:0] quantile_value;
    status_e            status;
  } out_word_t;

  // fixed-point format of samples, query points and kernel width
  localparam int FRAC_BITS = 16;
  localparam int SCALE_SHIFT = 48 - 2 * FRAC_BITS;
  localparam logic [31:0] KW_RESET = 32'(1) << FRAC_BITS;

  // one in Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  // exp argument limit, 16.0 in Q16
  localparam logic [20:0] EXP_LIMIT = 21'h10_0000;
  // 1/sqrt(2 pi) in Q32, split into an upper 15-bit and a lower 16-bit half
  localparam logic [14:0] INV_HI = 15'd26145;
  localparam logic [15:0] INV_LO = 16'd5327;

  // ceil(2^34 / k) for the series divisors k = 1 .. 9
  function automatic logic [34:0] recip(input logic [3:0] k);
    logic [34:0] m;
    unique case (k)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623062;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973837;
      4'd6:    m = 35'd2863311531;
      4'd7:    m = 35'd2454267027;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874354;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/gaussian_kde_with_quantiles_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_kde_with_quantiles_unit
// Sorted sample store with Gaussian kernel density and quantile queries.
// ----------------------------------------------------------------------------
// Samples live in one single-port-read RAM kept in ascending order; one word
// is handled at a time. A load shifts larger samples up one place, with a
// read state and a compare-and-write state per sample moved. A density query
// walks every stored sample; those within six kernel widths of the query
// point go through the shared bit-serial divider and the exp sequencer, the
// others are skipped, and a scaling step through the divider follows. The
// store needs no clearing pass after reset. A result word waits in an output
// register while the next input word is taken.
module gaussian_kde_with_quantiles_unit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gkq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gkq_pkg::out_word_t  out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int ACCW = CW + 31;
  localparam int SW   = ACCW - 14;
  localparam int NW   = SW + 32 - gkq_pkg::SCALE_SHIFT;
  localparam int DVW  = (NW > 49) ? NW : 49;
  localparam int DSW  = 32 + CW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_Q_RD    = 4'd4;
  localparam logic [3:0] S_Q_DAT   = 4'd5;
  localparam logic [3:0] S_D_RD    = 4'd6;
  localparam logic [3:0] S_D_DIFF  = 4'd7;
  localparam logic [3:0] S_D_CHK   = 4'd8;
  localparam logic [3:0] S_D_DIV   = 4'd9;
  localparam logic [3:0] S_D_EXP   = 4'd10;
  localparam logic [3:0] S_SC_MUL  = 4'd11;
  localparam logic [3:0] S_SC_DIV  = 4'd12;
  localparam logic [3:0] S_SC_WAIT = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  // control state
  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [31:0]    kw_q;
  logic           out_valid_q, out_valid_d;

  // payload state
  logic signed [31:0]  val_q, val_d;
  logic [ACCW-1:0]     acc_q, acc_d;
  logic [32:0]         mag_q, mag_d;
  logic [SW+14:0]      prod_hi_q;
  logic [SW+15:0]      prod_lo_q;
  logic [DSW-1:0]      den_q;
  gkq_pkg::out_word_t  res_q, res_d;
  gkq_pkg::out_word_t  out_word_q, out_word_d;

  // ram port
  logic           ram_we;
  logic [CW-1:0]  ram_widx;
  logic [31:0]    ram_wdata;
  logic [CW-1:0]  ram_ridx;
  logic [31:0]    ram_rdata;

  // divider and exp ports
  logic           div_start;
  logic [DVW-1:0] div_dividend;
  logic [DSW-1:0] div_divisor;
  logic           div_done;
  logic [DVW-1:0] div_quo;
  logic           exp_start;
  logic           exp_done;
  logic [30:0]    exp_p;

  // helpers
  logic [31:0]         sigma;
  logic [34:0]         six_sigma;
  logic [CW+15:0]      qprod;
  logic [CW-1:0]       qidx;
  logic signed [32:0]  diff;
  logic [SW+31:0]      full;
  logic                last;
  logic                out_free;

  always_comb begin
    sigma     = (kw_q == 32'd0) ? 32'd1 : kw_q;
    six_sigma = {3'b000, sigma} * 35'd6;
    qprod     = cnt_q * in_word_i.ratio;
    qidx      = (qprod[CW+15:16] >= cnt_q) ? cnt_q - 1'b1 : qprod[CW+15:16];
    diff      = 33'(val_q) - 33'(signed'(ram_rdata));
    full      = (SW+32)'({prod_hi_q, 16'd0}) + (SW+32)'(prod_lo_q);
    last      = (idx_q == cnt_q - 1'b1);
    out_free  = ~out_valid_q | ~out_stall_i;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    val_d        = val_q;
    acc_d        = acc_q;
    mag_d        = mag_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_word_d   = out_word_q;
    ram_we       = 1'b0;
    ram_widx     = idx_q;
    ram_wdata    = val_q;
    ram_ridx     = idx_q;
    div_start    = 1'b0;
    div_dividend = DVW'({mag_q, 16'd0});
    div_divisor  = DSW'(sigma);
    exp_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d = in_word_i.value;
          res_d = '{density: '0, quantile_value: '0, status: gkq_pkg::ST_OK};
          unique case (in_word_i.opcode)
            gkq_pkg::OP_LOAD: begin
              if (cnt_q == CW'(MAX_SAMPLES)) begin
                res_d.status = gkq_pkg::ST_FULL;
                state_d      = S_FIN;
              end else if (cnt_q == '0) begin
                ram_we    = 1'b1;
                ram_widx  = '0;
                ram_wdata = in_word_i.value;
                cnt_d     = CW'(1);
                state_d   = S_FIN;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            gkq_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_FIN;
            end
            gkq_pkg::OP_DENSITY: begin
              if (cnt_q == '0) begin
                res_d.status = gkq_pkg::ST_EMPTY;
                state_d      = S_FIN;
              end else begin
                idx_d   = '0;
                acc_d   = '0;
                state_d = S_D_RD;
              end
            end
            gkq_pkg::OP_QUANTILE: begin
              if (cnt_q == '0) begin
                res_d.status = gkq_pkg::ST_EMPTY;
                state_d      = S_FIN;
              end else begin
                idx_d   = qidx;
                state_d = S_Q_RD;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // insertion: move larger samples up one place
      S_INS_RD: begin
        ram_ridx = idx_q - 1'b1;
        state_d  = S_INS_CMP;
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (signed'(ram_rdata) > val_q) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - 1'b1;
          state_d   = (idx_q == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_FIN;
        end
      end
      S_INS_PUT: begin
        ram_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_FIN;
      end

      // quantile lookup
      S_Q_RD: state_d = S_Q_DAT;
      S_Q_DAT: begin
        res_d.quantile_value = signed'(ram_rdata);
        state_d              = S_FIN;
      end

      // density walk over the store
      S_D_RD: state_d = S_D_DIFF;
      S_D_DIFF: begin
        mag_d   = diff[32] ? 33'(-diff) : 33'(diff);
        state_d = S_D_CHK;
      end
      S_D_CHK: begin
        if ({2'b00, mag_q} > six_sigma) begin
          idx_d   = idx_q + 1'b1;
          state_d = last ? S_SC_MUL : S_D_RD;
        end else begin
          div_start = 1'b1;
          state_d   = S_D_DIV;
        end
      end
      S_D_DIV: begin
        if (div_done) begin
          exp_start = 1'b1;
          state_d   = S_D_EXP;
        end
      end
      S_D_EXP: begin
        if (exp_done) begin
          acc_d   = acc_q + ACCW'(exp_p);
          idx_d   = idx_q + 1'b1;
          state_d = last ? S_SC_MUL : S_D_RD;
        end
      end

      // scaling by 1/(sigma sqrt(2 pi) count)
      S_SC_MUL: state_d = S_SC_DIV;
      S_SC_DIV: begin
        div_start    = 1'b1;
        div_dividend = DVW'(full[SW+31:gkq_pkg::SCALE_SHIFT]);
        div_divisor  = den_q;
        state_d      = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (div_done) begin
          if (div_quo[DVW-1:32] != '0) begin
            res_d.density = '1;
            res_d.status  = gkq_pkg::ST_SATURATED;
          end else begin
            res_d.density = div_quo[31:0];
          end
          state_d = S_FIN;
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      kw_q        <= gkq_pkg::KW_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        kw_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    acc_q      <= acc_d;
    mag_q      <= mag_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
    if (state_q == S_SC_MUL) begin
      prod_hi_q <= acc_q[ACCW-1:14] * gkq_pkg::INV_HI;
      prod_lo_q <= acc_q[ACCW-1:14] * gkq_pkg::INV_LO;
      den_q     <= sigma * cnt_q;
    end
  end

  gkq_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_widx[AW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_ridx[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  gkq_div #(
    .DVW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  gkq_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(exp_start),
    .z_i    (div_quo[18:0]),
    .done_o (exp_done),
    .p_o    (exp_p)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ----- hw/rtl/gkq_ram.sv -----
// ----------------------------------------------------------------------------
// gkq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gkq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gkq_div.sv -----
// ----------------------------------------------------------------------------
// gkq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gkq_div #(
  parameter int DVW = 49,
  parameter int DSW = 43
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DSW-1:0]  rem_q;
  logic [DVW-1:0]  quo_q;
  logic [DSW-1:0]  dsr_q;

  logic [DSW:0]    shifted;
  logic [DSW+1:0]  trial;
  logic            ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[DVW-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = ~trial[DSW+1];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[DSW-1:0] : shifted[DSW-1:0];
      quo_q <= {quo_q[DVW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/gkq_exp.sv -----
// ----------------------------------------------------------------------------
// gkq_exp
// Kernel weight exp(-z^2/2) in Q30 from a Q16 normalised distance z: nine
// Horner steps of the series of exp(-a/32), then five squarings.
// ----------------------------------------------------------------------------
module gkq_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [18:0] z_i,
  output logic        done_o,
  output logic [30:0] p_o
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MUL1 = 3'd1;
  localparam logic [2:0] E_MUL2 = 3'd2;
  localparam logic [2:0] E_SUB  = 3'd3;
  localparam logic [2:0] E_SQ   = 3'd4;
  localparam logic [2:0] E_RND  = 3'd5;

  logic [2:0]  state_q;
  logic        done_q;
  logic [3:0]  k_q;
  logic [2:0]  n_q;
  logic [29:0] x_q;
  logic [30:0] p_q;
  logic [29:0] y_q;
  logic [29:0] q_q;
  logic [61:0] sq_q;

  logic [37:0] zz;
  logic [20:0] a;
  logic [60:0] xp;
  logic [64:0] yq;
  logic [61:0] rnd;

  always_comb begin
    zz  = z_i * z_i;
    a   = zz[37:17];
    xp  = x_q * p_q;
    yq  = y_q * gkq_pkg::recip(k_q);
    rnd = sq_q + 62'h2000_0000;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            if (a > gkq_pkg::EXP_LIMIT) begin
              done_q <= 1'b1;
            end else begin
              k_q     <= 4'd9;
              state_q <= E_MUL1;
            end
          end
        end
        E_MUL1: state_q <= E_MUL2;
        E_MUL2: state_q <= E_SUB;
        E_SUB: begin
          if (k_q == 4'd1) begin
            n_q     <= 3'd5;
            state_q <= E_SQ;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= E_MUL1;
          end
        end
        E_SQ: state_q <= E_RND;
        E_RND: begin
          n_q <= n_q - 1'b1;
          if (n_q == 3'd1) begin
            done_q  <= 1'b1;
            state_q <= E_IDLE;
          end else begin
            state_q <= E_SQ;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  // series and squaring datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          x_q <= {a, 9'd0};
          p_q <= (a > gkq_pkg::EXP_LIMIT) ? 31'd0 : gkq_pkg::Q30_ONE;
        end
      end
      E_MUL1: y_q  <= xp[59:30];
      E_MUL2: q_q  <= yq[63:34];
      E_SUB:  p_q  <= gkq_pkg::Q30_ONE - {1'b0, q_q};
      E_SQ:   sq_q <= p_q * p_q;
      E_RND:  p_q  <= rnd[60:30];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Gaussian kernel density unit. A stimulus table and random
// words, mostly near a cluster, are sent. Every result word is checked against
// a typed table entry or an in-bench density and quantile calculation.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned INV_SQRT_2PI_Q32 = 64'd1713444047;
  localparam int unsigned STALL_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  gkq_pkg::in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  gkq_pkg::out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [31:0] cfg_data = '0;

  // sorted sample copy and register copy
  logic signed [31:0] sample_copy [STORE_DEPTH];
  int unsigned        sample_total;
  logic [31:0]        width_copy;

  // expected result words in order of acceptance
  gkq_pkg::out_word_t result_fifo [8];
  int unsigned  fifo_wr = 0;
  int unsigned  fifo_rd = 0;
  int unsigned  errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  quiet_cycles = 0;
  logic signed [31:0] cluster_base = '0;

  gaussian_kde_with_quantiles_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // exp(-a) in Q30, a in Q16, truncated series then five squarings
  function automatic longint unsigned neg_exp_q30(input longint unsigned a);
    longint unsigned x;
    longint unsigned p;
    x = a << 9;
    p = ONE_Q30;
    for (int k = 9; k >= 1; k--) p = ONE_Q30 - ((x * p) >> 30) / k;
    for (int i = 0; i < 5; i++) p = (p * p + (ONE_Q30 >> 1)) >> 30;
    return p;
  endfunction

  function automatic longint unsigned gauss_term(input longint t, input longint d,
                                                 input longint unsigned sig);
    longint diff;
    longint unsigned mag;
    longint unsigned z;
    longint unsigned a;
    diff = t - d;
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    if (mag > 6 * sig) return 0;
    z = (mag << 16) / sig;
    a = (z * z) >> 17;
    if (a > (64'd16 << 16)) return 0;
    return neg_exp_q30(a);
  endfunction

  // expected result of one word, updating the store copy
  function automatic gkq_pkg::out_word_t kde_model_step(input gkq_pkg::in_word_t w);
    gkq_pkg::out_word_t r;
    longint unsigned sig;
    longint unsigned acc;
    longint unsigned n;
    longint unsigned q;
    longint unsigned idx;
    int unsigned pos;
    r = '0;
    r.status = gkq_pkg::ST_OK;
    case (w.opcode)
      gkq_pkg::OP_LOAD: begin
        if (sample_total >= STORE_DEPTH) r.status = gkq_pkg::ST_FULL;
        else begin
          pos = 0;
          while (pos < sample_total && sample_copy[pos] <= w.value) pos++;
          for (int i = sample_total; i > pos; i--) sample_copy[i] = sample_copy[i-1];
          sample_copy[pos] = w.value;
          sample_total++;
        end
      end
      gkq_pkg::OP_CLEAR: sample_total = 0;
      default: begin
        if (sample_total == 0) r.status = gkq_pkg::ST_EMPTY;
        else if (w.opcode == gkq_pkg::OP_DENSITY) begin
          sig = (width_copy == 0) ? 64'd1 : longint'(width_copy);
          acc = 0;
          for (int i = 0; i < sample_total; i++)
            acc += gauss_term(longint'(w.value), longint'(sample_copy[i]), sig);
          n = ((acc >> 14) * INV_SQRT_2PI_Q32) >> gkq_pkg::SCALE_SHIFT;
          q = n / (sig * sample_total);
          if (q > 64'hFFFF_FFFF) begin
            r.density = 32'hFFFF_FFFF;
            r.status = gkq_pkg::ST_SATURATED;
          end else r.density = q[31:0];
        end else begin
          idx = (longint'(sample_total) * w.ratio) >> 16;
          if (idx >= sample_total) idx = sample_total - 1;
          r.quantile_value = sample_copy[idx];
        end
      end
    endcase
    return r;
  endfunction

  // send one word; a typed expectation overrides the calculated one
  task automatic send_word(input gkq_pkg::in_word_t w, input bit use_typed,
                           input gkq_pkg::out_word_t typed);
    int unsigned gap;
    gkq_pkg::out_word_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predicted = kde_model_step(w);
    result_fifo[fifo_wr[2:0]] = use_typed ? typed : predicted;
    fifo_wr++;
  endtask

  // drain all results before touching the register
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fifo_wr != fifo_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_width(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_copy = v;
  endtask

  // value near the current cluster, or anywhere
  function automatic logic [31:0] pick_value();
    longint unsigned span;
    longint v;
    if ($urandom_range(0, 99) < 20) return $urandom;
    span = 6 * ((width_copy == 0) ? 64'd1 : longint'(width_copy));
    if (span > 64'h8000_0000) span = 64'h8000_0000;
    v = longint'(cluster_base) + longint'($urandom_range(0, span[31:0])) - longint'(span / 2);
    return v[31:0];
  endfunction

  // result word checker and receiver stalls
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (fifo_wr == fifo_rd) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        errors++;
      end else begin
        gkq_pkg::out_word_t e;
        e = result_fifo[fifo_rd[2:0]];
        fifo_rd++;
        if (out_word.density !== e.density) begin
          $display("%0t: density expected %h actual %h", $time, e.density, out_word.density);
          errors++;
        end
        if (out_word.quantile_value !== e.quantile_value) begin
          $display("%0t: quantile expected %h actual %h", $time, e.quantile_value,
                   out_word.quantile_value);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_word.status);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    gkq_pkg::op_e       op;
    logic [31:0]        value;
    logic [15:0]        ratio;
    bit                 typed;
    gkq_pkg::out_word_t result;
  } stim_row_t;

  localparam gkq_pkg::out_word_t R_OK    = '{32'd0, 32'sd0, gkq_pkg::ST_OK};
  localparam gkq_pkg::out_word_t R_EMPTY = '{32'd0, 32'sd0, gkq_pkg::ST_EMPTY};

  stim_row_t directed [] = '{
    '{gkq_pkg::OP_DENSITY,  32'h0000_0000, 16'd0,    1'b1, R_EMPTY},
    '{gkq_pkg::OP_QUANTILE, 32'h0000_0000, 16'hFFFF, 1'b1, R_EMPTY},
    '{gkq_pkg::OP_CLEAR,    32'h0000_0000, 16'd0,    1'b1, R_OK},
    '{gkq_pkg::OP_LOAD,     32'h0000_0000, 16'd0,    1'b1, R_OK},
    '{gkq_pkg::OP_DENSITY,  32'h0000_0000, 16'd0,    1'b1,
      '{32'd26145, 32'sd0, gkq_pkg::ST_OK}},
    '{gkq_pkg::OP_LOAD,     32'h7FFF_FFFF, 16'hFFFF, 1'b1, R_OK},
    '{gkq_pkg::OP_LOAD,     32'h8000_0000, 16'd0,    1'b1, R_OK},
    '{gkq_pkg::OP_LOAD,     32'h0000_0000, 16'd0,    1'b1, R_OK},
    '{gkq_pkg::OP_QUANTILE, 32'h0000_0000, 16'd0,    1'b1,
      '{32'd0, 32'sh8000_0000, gkq_pkg::ST_OK}},
    '{gkq_pkg::OP_QUANTILE, 32'h0000_0000, 16'hFFFF, 1'b1,
      '{32'd0, 32'sh7FFF_FFFF, gkq_pkg::ST_OK}},
    '{gkq_pkg::OP_QUANTILE, 32'hFFFF_FFFF, 16'h8000, 1'b0, R_OK},
    '{gkq_pkg::OP_DENSITY,  32'h7FFF_FFFF, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_DENSITY,  32'h8000_0000, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_DENSITY,  32'h0005_0000, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_LOAD,     32'hFFFF_0000, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_LOAD,     32'h0001_0001, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_DENSITY,  32'h0000_8000, 16'd0,    1'b0, R_OK},
    '{gkq_pkg::OP_QUANTILE, 32'h0000_0000, 16'h4000, 1'b0, R_OK},
    '{gkq_pkg::OP_CLEAR,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, R_OK},
    '{gkq_pkg::OP_LOAD,     32'h1234_5678, 16'd0,    1'b1, R_OK},
    '{gkq_pkg::OP_QUANTILE, 32'h0000_0000, 16'h1234, 1'b1,
      '{32'd0, 32'sh1234_5678, gkq_pkg::ST_OK}},
    '{gkq_pkg::OP_CLEAR,    32'h0000_0000, 16'd0,    1'b1, R_OK}
  };

  logic [31:0] width_plan [6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, gkq_pkg::KW_RESET,
                                  32'h0004_0000, 32'h0000_0000};

  initial begin
    gkq_pkg::in_word_t w;
    int unsigned r;
    width_copy = gkq_pkg::KW_RESET;
    sample_total = 0;
    width_plan[5] = $urandom_range(1, 32'h0010_0000);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset width
    foreach (directed[i]) begin
      w.opcode = directed[i].op;
      w.value = directed[i].value;
      w.ratio = directed[i].ratio;
      send_word(w, directed[i].typed, directed[i].result);
    end

    // random phases over several kernel widths and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_width(width_plan[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      cluster_base = $urandom;
      for (int n = 0; n < 67; n++) begin
        r = $urandom_range(0, 99);
        w.opcode = (r < 40) ? gkq_pkg::OP_LOAD : (r < 45) ? gkq_pkg::OP_CLEAR :
                   (r < 72) ? gkq_pkg::OP_DENSITY : gkq_pkg::OP_QUANTILE;
        if (w.opcode == gkq_pkg::OP_LOAD && sample_total >= 24) w.opcode = gkq_pkg::OP_CLEAR;
        if (w.opcode == gkq_pkg::OP_CLEAR) cluster_base = $urandom;
        w.value = pick_value();
        w.ratio = 16'($urandom);
        send_word(w, 1'b0, '0);
      end
    end

    // drain and finish
    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- gaussian_kde_with_quantiles_unit.f -----
hw/rtl/gkq_pkg.sv
hw/rtl/gkq_ram.sv
hw/rtl/gkq_div.sv
hw/rtl/gkq_exp.sv
hw/rtl/gaussian_kde_with_quantiles_unit.sv
dv/tb_top.sv
